>>> rtl/spi_mram_command_sequencer_assert.svh
// assertion macros for the spi mram command sequencer
`ifndef SPI_MRAM_COMMAND_SEQUENCER_ASSERT_SVH
`define SPI_MRAM_COMMAND_SEQUENCER_ASSERT_SVH

// condition implies consequence in the same cycle
`define SMCS_ASSERT_SAME(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// condition implies consequence in the next cycle
`define SMCS_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

>>> rtl/smcs_pkg.sv
// shared types and constants for the spi mram command sequencer
`default_nettype none
package smcs_pkg;

   localparam int CHIPS = 4;
   localparam int MAX_LEN = 1024;
   localparam int CHIP_IDX_W = (CHIPS > 1) ? $clog2(CHIPS) : 1;

   localparam logic [24:0] ADR_LIMIT = 25'h020000;
   localparam logic [7:0] STATUS_MASK = 8'hFD;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 88;

   localparam logic [7:0] OP_NONE = 8'h00;
   localparam logic [7:0] OP_RDSR = 8'h05;
   localparam logic [7:0] OP_READ = 8'h03;
   localparam logic [7:0] OP_WREN = 8'h06;
   localparam logic [7:0] OP_WRITE = 8'h02;
   localparam logic [7:0] OP_WRDI = 8'h04;

   typedef enum logic [2:0] {
      CMD_INIT  = 3'd0,
      CMD_READ  = 3'd1,
      CMD_WRITE = 3'd2,
      CMD_DONE  = 3'd3,
      CMD_POLL  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_NOINIT = 3'd0,
      ST_INIT   = 3'd1,
      ST_IDLE   = 3'd2,
      ST_RX     = 3'd3,
      ST_WREN   = 3'd4,
      ST_TX     = 3'd5,
      ST_WRDIS  = 3'd6,
      ST_ERR    = 3'd7
   } chip_state_type;

   typedef enum logic [1:0] {
      KIND_JOB      = 2'd0,
      KIND_COMPLETE = 2'd1,
      KIND_ERROR    = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      RC_OK       = 3'd0,
      RC_BAD_CHIP = 3'd1,
      RC_BUSY     = 3'd2,
      RC_NO_BUF   = 3'd3,
      RC_LEN      = 3'd4,
      RC_ADDR     = 3'd5
   } result_code_type;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  chip;
      logic [23:0] address;
      logic [15:0] length;
      logic        buffer_present;
      logic        job_ok;
      logic [7:0]  status_byte;
      logic [1:0]  bus_id;
      logic        generic_spi;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  chip_out;
      logic [7:0]  opcode;
      logic [23:0] address_out;
      logic [10:0] tx_count;
      logic [10:0] rx_count;
      logic [2:0]  result_code;
      logic [15:0] length_out;
      logic [1:0]  bus_out;
      logic        generic_out;
      logic [2:0]  prior_state;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } result_type;

   typedef struct packed {
      chip_state_type state;
      logic           busy;
      logic [23:0]    address;
      logic [15:0]    length;
      logic [1:0]     bus;
      logic           generic;
   } chip_rec_type;

   typedef struct packed {
      logic                  en;
      logic [CHIP_IDX_W-1:0] index;
      chip_rec_type          rec;
   } chip_wr_type;

endpackage
`default_nettype wire

>>> rtl/smcs_chip_regs.sv
// per-chip state registers with one read and one write port
`default_nettype none
module smcs_chip_regs (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [smcs_pkg::CHIP_IDX_W-1:0] rd_index,
   output smcs_pkg::chip_rec_type               rd_rec,
   input  wire smcs_pkg::chip_wr_type           wr
);
   import smcs_pkg::*;

   chip_rec_type rec_ff [CHIPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHIPS; i++) begin
            rec_ff[i] <= '0;
         end
      end else if (wr.en) begin
         rec_ff[wr.index] <= wr.rec;
      end
   end

   assign rd_rec = rec_ff[rd_index];

endmodule
`default_nettype wire

>>> rtl/smcs_engine.sv
// command decode, request checks and chip state transitions for one item
`default_nettype none
module smcs_engine (
   input  wire smcs_pkg::req_item_type  item,
   input  wire smcs_pkg::chip_rec_type  rec,
   output smcs_pkg::result_type         result,
   output smcs_pkg::chip_wr_type        wr
);
   import smcs_pkg::*;

   logic            chip_ok;
   logic [24:0]     end_addr;
   result_code_type check_code;
   rsp_item_type    job;

   assign chip_ok = {1'b0, item.chip} < 9'(CHIPS);
   assign end_addr = {1'b0, item.address} + {9'd0, item.length};

   always_comb begin
      if (!chip_ok) begin
         check_code = RC_BAD_CHIP;
      end else if (rec.state != ST_IDLE) begin
         check_code = RC_BUSY;
      end else if (!item.buffer_present) begin
         check_code = RC_NO_BUF;
      end else if (item.length > 16'(MAX_LEN)) begin
         check_code = RC_LEN;
      end else if (end_addr > ADR_LIMIT) begin
         check_code = RC_ADDR;
      end else begin
         check_code = RC_OK;
      end
   end

   always_comb begin
      job = '0;
      job.kind = KIND_JOB;
      job.chip_out = item.chip;
      job.bus_out = rec.bus;
      job.generic_out = rec.generic;

      result = '0;
      wr.en = 1'b0;
      wr.index = item.chip[CHIP_IDX_W-1:0];
      wr.rec = rec;

      case (item.command)
         CMD_READ, CMD_WRITE: begin
            result.valid = 1'b1;
            if (check_code != RC_OK) begin
               result.item.kind = KIND_COMPLETE;
               result.item.chip_out = item.chip;
               result.item.address_out = item.address;
               result.item.result_code = check_code;
               result.item.length_out = item.length;
            end else begin
               wr.en = 1'b1;
               wr.rec.busy = 1'b1;
               wr.rec.address = item.address;
               wr.rec.length = item.length;
               result.item = job;
               if (item.command == CMD_WRITE) begin
                  wr.rec.state = ST_WREN;
                  result.item.opcode = OP_WREN;
                  result.item.tx_count = 11'd1;
               end else begin
                  wr.rec.state = ST_RX;
                  result.item.opcode = OP_READ;
                  result.item.address_out = {7'd0, item.address[16:0]};
                  result.item.tx_count = 11'd4;
                  result.item.rx_count = item.length[10:0];
               end
            end
         end
         CMD_INIT: begin
            if (chip_ok) begin
               wr.en = 1'b1;
               wr.rec.state = ST_NOINIT;
               wr.rec.bus = item.bus_id;
               wr.rec.generic = item.generic_spi;
               result.valid = 1'b1;
               result.item = job;
               result.item.opcode = OP_RDSR;
               result.item.tx_count = 11'd1;
               result.item.rx_count = 11'd1;
               result.item.bus_out = item.bus_id;
               result.item.generic_out = item.generic_spi;
            end
         end
         CMD_DONE: begin
            if (chip_ok) begin
               wr.en = 1'b1;
               wr.rec.busy = 1'b0;
               if (item.job_ok) begin
                  if (rec.state == ST_NOINIT) begin
                     wr.rec.state = ((item.status_byte & STATUS_MASK) != 8'd0) ?
                                    ST_ERR : ST_INIT;
                  end
               end else begin
                  wr.rec.state = ST_ERR;
                  result.valid = 1'b1;
                  result.item.kind = KIND_ERROR;
                  result.item.chip_out = item.chip;
                  result.item.bus_out = rec.bus;
                  result.item.generic_out = rec.generic;
                  result.item.prior_state = rec.state;
               end
            end
         end
         CMD_POLL: begin
            if (chip_ok && !rec.busy) begin
               case (rec.state)
                  ST_RX, ST_WRDIS: begin
                     wr.en = 1'b1;
                     wr.rec.state = ST_IDLE;
                     result.valid = 1'b1;
                     result.item.kind = KIND_COMPLETE;
                     result.item.chip_out = item.chip;
                     result.item.address_out = rec.address;
                     result.item.length_out = rec.length;
                  end
                  ST_WREN: begin
                     wr.en = 1'b1;
                     wr.rec.busy = 1'b1;
                     wr.rec.state = ST_TX;
                     result.valid = 1'b1;
                     result.item = job;
                     result.item.opcode = OP_WRITE;
                     result.item.address_out = {7'd0, rec.address[16:0]};
                     result.item.tx_count = rec.length[10:0] + 11'd4;
                  end
                  ST_TX: begin
                     wr.en = 1'b1;
                     wr.rec.busy = 1'b1;
                     wr.rec.state = ST_WRDIS;
                     result.valid = 1'b1;
                     result.item = job;
                     result.item.opcode = OP_WRDI;
                     result.item.tx_count = 11'd1;
                  end
                  ST_INIT: begin
                     wr.en = 1'b1;
                     wr.rec.state = ST_IDLE;
                  end
                  default: begin
                     wr.en = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            wr.en = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/spi_mram_command_sequencer.sv
// top level of the spi mram command sequencer: item registers and result register
//
// Usage
// The req_ channel carries one command item per handshake: init, read
// request, write request, bus job finished or poll tick for one chip.
// The rsp_ channel carries zero or one result item per command: an issued
// bus job (opcode, address, byte counts, routing), a request completion with
// its result code, or a bus job error event.
// An accepted item sits in the input register until the result register is
// free or being emptied; its result is formed from the chip's stored state and
// loaded into the result register, which drives rsp_tvalid.
// One item is accepted per cycle, back to back, as long as the result
// register is empty or its item is taken in the same cycle.
// When the receiver holds rsp_tready low, the result stays put, the item
// behind it waits in the input register and req_tready drops.
// Synchronous reset clears the valid bits of both registers and returns every
// chip to the not initialized state with busy clear and zero saved fields.
`default_nettype none
module spi_mram_command_sequencer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   // chip, address, length, buffer_present, job_ok, status_byte, bus_id, generic_spi
   input  wire logic [smcs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command
   input  wire logic [2:0]                          req_tuser,
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // chip_out, opcode, address_out, tx_count, rx_count, result_code,
   // length_out, bus_out, generic_out, prior_state
   output      logic [smcs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // kind
   output      logic [1:0]                          rsp_tuser
);
   import smcs_pkg::*;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   req_item_type in_item_in;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   logic         advance;
   chip_rec_type rec;
   result_type   result;
   chip_wr_type  wr;
   chip_wr_type  wr_gated;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_item_in.command = req_tuser;
      in_item_in.chip = req_tdata[7:0];
      in_item_in.address = req_tdata[31:8];
      in_item_in.length = req_tdata[47:32];
      in_item_in.buffer_present = req_tdata[48];
      in_item_in.job_ok = req_tdata[49];
      in_item_in.status_byte = req_tdata[57:50];
      in_item_in.bus_id = req_tdata[59:58];
      in_item_in.generic_spi = req_tdata[60];
   end

   always_comb begin
      wr_gated = wr;
      wr_gated.en = wr.en && advance;
   end

   smcs_chip_regs u_chip_regs (
      .clock    (clock),
      .reset    (reset),
      .rd_index (in_item_ff.chip[CHIP_IDX_W-1:0]),
      .rd_rec   (rec),
      .wr       (wr_gated)
   );

   smcs_engine u_engine (
      .item   (in_item_ff),
      .rec    (rec),
      .result (result),
      .wr     (wr)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= result.valid;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_tready && req_tvalid) begin
         in_item_ff <= in_item_in;
      end
      if (advance && result.valid) begin
         out_item_ff <= result.item;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = out_item_ff.kind;
   assign rsp_tdata = {1'b0,
                       out_item_ff.prior_state,
                       out_item_ff.generic_out,
                       out_item_ff.bus_out,
                       out_item_ff.length_out,
                       out_item_ff.result_code,
                       out_item_ff.rx_count,
                       out_item_ff.tx_count,
                       out_item_ff.address_out,
                       out_item_ff.opcode,
                       out_item_ff.chip_out};

`include "spi_mram_command_sequencer_assert.svh"

   `SMCS_ASSERT_SAME(a_stall_blocks_input, clock, reset,
      in_valid_ff && out_valid_ff && !rsp_tready, !req_tready,
      "input taken while result register is stalled")

   `SMCS_ASSERT_SAME(a_job_opcode, clock, reset,
      out_valid_ff && out_item_ff.kind == KIND_JOB,
      out_item_ff.opcode == OP_RDSR || out_item_ff.opcode == OP_READ ||
      out_item_ff.opcode == OP_WREN || out_item_ff.opcode == OP_WRITE ||
      out_item_ff.opcode == OP_WRDI,
      "issued job carries an unknown opcode")

   `SMCS_ASSERT_SAME(a_write_valid_chip, clock, reset,
      advance && wr.en, {1'b0, in_item_ff.chip} < 9'(CHIPS),
      "state update for a chip index out of range")

   `SMCS_ASSERT_NEXT(a_error_sets_state, clock, reset,
      advance && result.valid && result.item.kind == KIND_ERROR,
      rec.state == ST_ERR || in_item_ff.chip != $past(in_item_ff.chip),
      "error event without the chip entering the error state")

endmodule
`default_nettype wire
